### sv/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg: shared types and codes for the sorted list table
// Request and result beat layouts, request kinds and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

	// Request kinds.
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_SEARCH = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_MISSING = 2'd2;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned POS_W   = 6;
	localparam int unsigned CNT_W   = 7;

	// One request beat.
	typedef struct packed {
		logic [1:0]                kind;
		logic signed [VALUE_W-1:0] value;
	} req_t;

	// One result beat.
	typedef struct packed {
		logic [1:0]       status;
		logic             found;
		logic [POS_W-1:0] position;
		logic [CNT_W-1:0] entry_count;
	} rsp_t;

	// Per-request controls broadcast to every cell.
	typedef struct packed {
		logic                      do_insert;
		logic                      do_remove;
		logic signed [VALUE_W-1:0] value;
	} cell_ctl_t;

endpackage

`default_nettype wire

### sv/slt_cell.sv
// ----------------------------------------------------------------------------
// slt_cell: one entry of the sorted list table
// Holds one entry, compares it with the request value, and on an update
// keeps its entry, takes the new value, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_cell (
	input  wire logic                           clk,
	input  wire slt_pkg::cell_ctl_t             ctl,
	input  wire logic                           occupied,
	input  wire logic                           left_lt,
	input  wire logic signed [slt_pkg::VALUE_W-1:0] left_entry,
	input  wire logic signed [slt_pkg::VALUE_W-1:0] right_entry,
	output logic signed [slt_pkg::VALUE_W-1:0]  entry_q,
	output logic                                lt,
	output logic                                eq,
	output logic                                boundary
);
	import slt_pkg::*;

	// Compare the stored entry with the request value.
	assign lt       = occupied && (entry_q < ctl.value);
	assign eq       = occupied && (entry_q == ctl.value);
	// This cell is the first one whose entry is not smaller.
	assign boundary = left_lt && !lt;

	// Insert shifts entries up from the boundary; remove shifts them down.
	always_ff @(posedge clk) begin
		if (ctl.do_insert && !lt) begin
			entry_q <= left_lt ? ctl.value : left_entry;
		end else if (ctl.do_remove && !lt) begin
			entry_q <= right_entry;
		end
	end

endmodule

`default_nettype wire

### sv/sorted_list_table.sv
// ----------------------------------------------------------------------------
// sorted_list_table: bounded table of signed integers in ascending order
// Insert, remove and search requests against a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat (kind, value) is taken at a rising edge where start is
//   high and busy is low. busy stays low, so a new request may be issued in
//   every cycle; the table is updated at the edge that takes the request.
//   One result beat follows per request. It is on rsp, marked by done for
//   exactly one cycle, in the cycle after the request was taken.
//   The receiver cannot stall; results are not queued past the next request.
//   Throughput is one request per cycle. Each cell compares its entry with
//   the request value in parallel and shifts in one step, so the figure is
//   set by the compare across the row plus the found/position reduction.
//   Reset clears the entry count and the result strobe. Entry storage is not
//   cleared; only entries below the count are ever looked at.
//   Insert into a full table reports status full; remove or search of an
//   absent value reports not found. Kind 3 leaves the table as it is.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_table #(
	parameter int unsigned TABLE_DEPTH = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire slt_pkg::req_t req,
	output logic               done,
	output slt_pkg::rsp_t      rsp
);
	import slt_pkg::*;

	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CNT_WIDTH = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_WIDTH-1:0] DEPTH_CNT = CNT_WIDTH'(TABLE_DEPTH);

	logic [CNT_WIDTH-1:0]        count_q;
	logic                        done_q;
	rsp_t                        rsp_q;
	rsp_t                        rsp_next;

	logic                        accept;
	logic                        is_insert;
	logic                        is_remove;
	logic                        is_search;
	logic                        full;
	logic                        hit;
	logic [IDX_W-1:0]            hit_idx;
	logic [31:0]                 idx_wide;
	logic [31:0]                 cnt_wide;
	logic [CNT_WIDTH-1:0]        count_next;
	cell_ctl_t                   ctl;

	logic signed [VALUE_W-1:0]   entries [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0]      lt_vec;
	logic [TABLE_DEPTH-1:0]      eq_vec;
	logic [TABLE_DEPTH-1:0]      bnd_vec;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Decode the request.
	assign is_insert = accept && (req.kind == KIND_INSERT);
	assign is_remove = accept && (req.kind == KIND_REMOVE);
	assign is_search = accept && (req.kind == KIND_SEARCH);
	assign full      = (count_q == DEPTH_CNT);

	// A match exists only at the boundary cell, since equal entries follow
	// the smaller ones.
	assign hit = |(bnd_vec & eq_vec);

	// Encode the boundary cell's index.
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (bnd_vec[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
		end
	end

	// Controls broadcast to the cells.
	always_comb begin
		ctl.do_insert = is_insert && !full;
		ctl.do_remove = is_remove && hit;
		ctl.value     = req.value;
	end

	// Row of cells.
	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		logic                      occ;
		logic                      l_lt;
		logic signed [VALUE_W-1:0] l_ent;
		logic signed [VALUE_W-1:0] r_ent;

		assign occ = (CNT_WIDTH'(g) < count_q);
		if (g == 0) begin : g_first
			assign l_lt  = 1'b1;
			assign l_ent = req.value;
		end else begin : g_mid
			assign l_lt  = lt_vec[g-1];
			assign l_ent = entries[g-1];
		end
		if (g == TABLE_DEPTH - 1) begin : g_last
			assign r_ent = entries[g];
		end else begin : g_inner
			assign r_ent = entries[g+1];
		end

		slt_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occupied    (occ),
			.left_lt     (l_lt),
			.left_entry  (l_ent),
			.right_entry (r_ent),
			.entry_q     (entries[g]),
			.lt          (lt_vec[g]),
			.eq          (eq_vec[g]),
			.boundary    (bnd_vec[g])
		);
	end

	// Next entry count.
	always_comb begin
		count_next = count_q;
		if (ctl.do_insert) begin
			count_next = count_q + 1'b1;
		end else if (ctl.do_remove) begin
			count_next = count_q - 1'b1;
		end
	end

	assign idx_wide = 32'(hit_idx);
	assign cnt_wide = 32'(count_next);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_next;
			done_q  <= accept;
		end
	end

	// Next result beat.
	always_comb begin
		rsp_next.status      = ST_DONE;
		rsp_next.found       = 1'b0;
		rsp_next.position    = '0;
		rsp_next.entry_count = cnt_wide[CNT_W-1:0];
		if (is_insert) begin
			if (full) begin
				rsp_next.status = ST_FULL;
			end else begin
				rsp_next.position = idx_wide[POS_W-1:0];
			end
		end else if (is_remove || is_search) begin
			if (hit) begin
				rsp_next.found    = 1'b1;
				rsp_next.position = idx_wide[POS_W-1:0];
			end else begin
				rsp_next.status = ST_MISSING;
			end
		end
	end

	// Result beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_next;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire
